FILE: src/bfp_pkg.sv
// Shared types, codes and defaults for the best-fit two-resource placement block.
`timescale 1ns / 1ps

package bfp_pkg;

    localparam int DEF_NUM_BINS  = 16;
    localparam int DEF_NUM_MODES = 16;

    localparam int IDX_W   = 4;
    localparam int MODE_W  = 4;
    localparam int AMT_W   = 16;
    localparam int MASK_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int TOTAL_W = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 56;

    // Operation codes carried on the input tuser
    localparam logic [OP_W-1:0] OP_CONFIG  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLACE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Result codes carried on the output tuser
    localparam logic [STAT_W-1:0] ST_CONFIGURED = 2'd0;
    localparam logic [STAT_W-1:0] ST_PLACED     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_FIT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_RELEASED   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [AMT_W-1:0]  bw;
        logic [AMT_W-1:0]  pw;
    } bin_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CFG,
        S_SCAN,
        S_SCAN_END,
        S_PLACE,
        S_REL_RD,
        S_REL_WR
    } bfp_state_t;

endpackage

FILE: src/bfp_table.sv
// Bin table: synchronous entry memory plus per-bin valid flags.
`timescale 1ns / 1ps

module bfp_table #(
    parameter  int NUM_BINS = bfp_pkg::DEF_NUM_BINS,
    localparam int BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [BIN_W-1:0]              wr_addr,
    input  bfp_pkg::bin_entry_t           wr_entry,
    input  logic                          rd_en,
    input  logic [BIN_W-1:0]              rd_addr,
    output bfp_pkg::bin_entry_t           rd_entry,
    output logic                          rd_valid
);

    bfp_pkg::bin_entry_t mem [NUM_BINS];
    logic [NUM_BINS-1:0] valid_reg;
    bfp_pkg::bin_entry_t rd_entry_reg;
    logic                rd_valid_reg;

    // Entry storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // Any write marks the bin as loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

FILE: src/best_fit_two_resource_placement_top.sv
// Top level of the best-fit two-resource bin placement block.
`timescale 1ns / 1ps
// Configure writes in S_CFG; release reads in S_REL_RD and writes in S_REL_WR; place scans
// every bin in S_SCAN, passes S_SCAN_END and commits in S_PLACE. Each result loads once the
// result register is free. One item is in work at a time and the input reopens once the
// result loads; the scan reads one bin per cycle through the table's single read port.
// The next item is accepted while a result waits on m_axis_tready. Reset clears the valid
// flags, the gain total and control state; bin contents stay undefined until configured.

module best_fit_two_resource_placement_top #(
    parameter int NUM_BINS  = bfp_pkg::DEF_NUM_BINS,
    parameter int NUM_MODES = bfp_pkg::DEF_NUM_MODES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bin_index[3:0], bin_mode[7:4], bw_amount[23:8], pw_amount[39:24],
    // compat_mask[55:40], gain[71:56]
    input  logic [bfp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  logic [bfp_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // chosen_bin[3:0], leftover_bw[19:4], total_gain[51:20], zero pad[55:52]
    output logic [bfp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [bfp_pkg::STAT_W-1:0]      m_axis_tuser
);

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CNT_W = $clog2(NUM_BINS + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bfp_pkg::bfp_state_t state_reg, state_next;

    // Held fields of the transaction in work
    logic [bfp_pkg::IDX_W-1:0]   idx_reg;
    logic [bfp_pkg::MODE_W-1:0]  mode_reg;
    logic [bfp_pkg::AMT_W-1:0]   bw_reg;
    logic [bfp_pkg::AMT_W-1:0]   pw_reg;
    logic [bfp_pkg::MASK_W-1:0]  mask_reg;
    logic [bfp_pkg::GAIN_W-1:0]  gain_reg;

    // Scan bookkeeping
    logic [CNT_W-1:0]            scan_cnt_reg, scan_cnt_next;
    logic                        eval_reg, eval_next;
    logic [BIN_W-1:0]            eval_idx_reg, eval_idx_next;
    logic                        found_reg, found_next;
    logic [BIN_W-1:0]            best_idx_reg, best_idx_next;
    logic [bfp_pkg::AMT_W-1:0]   best_left_reg, best_left_next;
    logic [bfp_pkg::AMT_W-1:0]   best_pw_reg, best_pw_next;
    logic [bfp_pkg::MODE_W-1:0]  best_mode_reg, best_mode_next;

    logic [bfp_pkg::TOTAL_W-1:0] total_reg, total_next;

    // Result register
    logic                        out_valid_reg, out_valid_next;
    logic [bfp_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [bfp_pkg::IDX_W-1:0]   out_bin_reg, out_bin_next;
    logic [bfp_pkg::AMT_W-1:0]   out_left_reg, out_left_next;

    // ------------------------------------------------------------------
    // Table interface
    // ------------------------------------------------------------------
    logic                tbl_wr_en;
    logic [BIN_W-1:0]    tbl_wr_addr;
    bfp_pkg::bin_entry_t tbl_wr_entry;
    logic                tbl_rd_en;
    logic [BIN_W-1:0]    tbl_rd_addr;
    bfp_pkg::bin_entry_t tbl_rd_entry;
    logic                tbl_rd_valid;

    bfp_table #(
        .NUM_BINS (NUM_BINS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_entry (tbl_wr_entry),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_entry (tbl_rd_entry),
        .rd_valid (tbl_rd_valid)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    logic                        in_accept;
    logic                        out_free;
    logic [7:0]                  idx_wide;
    logic [BIN_W-1:0]            idx_addr;
    logic                        idx_in_range;
    logic [7:0]                  best_wide;
    logic [BIN_W-1:0]            scan_addr;

    logic                        mode_ok;
    logic                        fits;
    logic [bfp_pkg::AMT_W-1:0]   cand_left;
    logic                        take;

    logic [bfp_pkg::TOTAL_W:0]   gain_sum;
    logic [bfp_pkg::TOTAL_W-1:0] total_add;
    logic [bfp_pkg::TOTAL_W-1:0] total_sub;
    logic [bfp_pkg::AMT_W:0]     rel_bw_sum;
    logic [bfp_pkg::AMT_W:0]     rel_pw_sum;
    logic [bfp_pkg::AMT_W-1:0]   rel_bw;
    logic [bfp_pkg::AMT_W-1:0]   rel_pw;
    logic                        rel_ok;

    assign in_accept    = s_axis_tvalid && s_axis_tready;
    // A finished result may be loaded once the waiting one is taken or gone
    assign out_free     = !out_valid_reg || m_axis_tready;

    assign idx_wide     = 8'(idx_reg);
    assign idx_addr     = idx_wide[BIN_W-1:0];
    assign idx_in_range = (idx_wide < 8'(NUM_BINS));
    assign best_wide    = 8'(best_idx_reg);
    assign scan_addr    = scan_cnt_reg[BIN_W-1:0];

    // Candidate test on the entry returned by the previous scan read.
    // A mode at or above NUM_MODES never matches.
    assign mode_ok   = (32'(tbl_rd_entry.mode) < NUM_MODES) && mask_reg[tbl_rd_entry.mode];
    assign fits      = tbl_rd_valid && mode_ok
                       && (bw_reg <= tbl_rd_entry.bw) && (pw_reg <= tbl_rd_entry.pw);
    assign cand_left = tbl_rd_entry.bw - bw_reg;
    // Strict less-than keeps the lowest index on a tie
    assign take      = eval_reg && fits && (!found_reg || (cand_left < best_left_reg));

    // Saturating gain arithmetic
    assign gain_sum  = {1'b0, total_reg} + (bfp_pkg::TOTAL_W + 1)'(gain_reg);
    assign total_add = gain_sum[bfp_pkg::TOTAL_W] ? '1 : gain_sum[bfp_pkg::TOTAL_W-1:0];
    assign total_sub = (total_reg >= bfp_pkg::TOTAL_W'(gain_reg))
                       ? (total_reg - bfp_pkg::TOTAL_W'(gain_reg)) : '0;

    // Release returns resources, clamped at full scale
    assign rel_bw_sum = {1'b0, tbl_rd_entry.bw} + {1'b0, bw_reg};
    assign rel_pw_sum = {1'b0, tbl_rd_entry.pw} + {1'b0, pw_reg};
    assign rel_bw     = rel_bw_sum[bfp_pkg::AMT_W] ? '1 : rel_bw_sum[bfp_pkg::AMT_W-1:0];
    assign rel_pw     = rel_pw_sum[bfp_pkg::AMT_W] ? '1 : rel_pw_sum[bfp_pkg::AMT_W-1:0];
    assign rel_ok     = idx_in_range && tbl_rd_valid;

    // ------------------------------------------------------------------
    // Sequencer: next state, table accesses and result load
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        eval_next       = 1'b0;
        eval_idx_next   = scan_addr;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_left_next  = best_left_reg;
        best_pw_next    = best_pw_reg;
        best_mode_next  = best_mode_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_bin_next    = out_bin_reg;
        out_left_next   = out_left_reg;

        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = idx_addr;
        tbl_wr_entry    = '{mode: mode_reg, bw: bw_reg, pw: pw_reg};
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = idx_addr;

        s_axis_tready   = (state_reg == bfp_pkg::S_IDLE);

        // Fold in the entry read in the previous cycle
        if (take)
        begin
            found_next     = 1'b1;
            best_idx_next  = eval_idx_reg;
            best_left_next = cand_left;
            best_pw_next   = tbl_rd_entry.pw - pw_reg;
            best_mode_next = tbl_rd_entry.mode;
        end

        case (state_reg)
            bfp_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    case (s_axis_tuser)
                        bfp_pkg::OP_CONFIG:  state_next = bfp_pkg::S_CFG;
                        bfp_pkg::OP_PLACE:   state_next = bfp_pkg::S_SCAN;
                        bfp_pkg::OP_RELEASE: state_next = bfp_pkg::S_REL_RD;
                        default:             state_next = bfp_pkg::S_IDLE;
                    endcase
                end
            end

            bfp_pkg::S_CFG:
            begin
                if (out_free)
                begin
                    tbl_wr_en       = idx_in_range;
                    out_valid_next  = 1'b1;
                    out_status_next = bfp_pkg::ST_CONFIGURED;
                    out_bin_next    = idx_reg;
                    out_left_next   = idx_in_range ? bw_reg : '0;
                    state_next      = bfp_pkg::S_IDLE;
                end
            end

            bfp_pkg::S_SCAN:
            begin
                // Issue one read per cycle; the compare follows in the next cycle
                tbl_rd_en     = 1'b1;
                tbl_rd_addr   = scan_addr;
                eval_next     = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == CNT_W'(NUM_BINS - 1))
                begin
                    state_next = bfp_pkg::S_SCAN_END;
                end
            end

            bfp_pkg::S_SCAN_END:
            begin
                state_next = bfp_pkg::S_PLACE;
            end

            bfp_pkg::S_PLACE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        tbl_wr_en       = 1'b1;
                        tbl_wr_addr     = best_idx_reg;
                        tbl_wr_entry    = '{mode: best_mode_reg, bw: best_left_reg,
                                            pw: best_pw_reg};
                        total_next      = total_add;
                        out_status_next = bfp_pkg::ST_PLACED;
                        out_bin_next    = best_wide[bfp_pkg::IDX_W-1:0];
                        out_left_next   = best_left_reg;
                    end
                    else
                    begin
                        out_status_next = bfp_pkg::ST_NO_FIT;
                        out_bin_next    = '0;
                        out_left_next   = '0;
                    end
                    state_next = bfp_pkg::S_IDLE;
                end
            end

            bfp_pkg::S_REL_RD:
            begin
                tbl_rd_en  = 1'b1;
                state_next = bfp_pkg::S_REL_WR;
            end

            bfp_pkg::S_REL_WR:
            begin
                // Read data holds while the result register is busy
                if (out_free)
                begin
                    if (rel_ok)
                    begin
                        tbl_wr_en  = 1'b1;
                        tbl_wr_entry = '{mode: tbl_rd_entry.mode, bw: rel_bw, pw: rel_pw};
                        total_next = total_sub;
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = bfp_pkg::ST_RELEASED;
                    out_bin_next    = idx_reg;
                    out_left_next   = rel_ok ? rel_bw : '0;
                    state_next      = bfp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bfp_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfp_pkg::S_IDLE;
            scan_cnt_reg  <= '0;
            eval_reg      <= 1'b0;
            found_reg     <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            eval_reg      <= eval_next;
            found_reg     <= found_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            idx_reg  <= s_axis_tdata[3:0];
            mode_reg <= s_axis_tdata[7:4];
            bw_reg   <= s_axis_tdata[23:8];
            pw_reg   <= s_axis_tdata[39:24];
            mask_reg <= s_axis_tdata[55:40];
            gain_reg <= s_axis_tdata[71:56];
        end
        eval_idx_reg   <= eval_idx_next;
        best_idx_reg   <= best_idx_next;
        best_left_reg  <= best_left_next;
        best_pw_reg    <= best_pw_next;
        best_mode_reg  <= best_mode_next;
        out_status_reg <= out_status_next;
        out_bin_reg    <= out_bin_next;
        out_left_reg   <= out_left_next;
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'b0000, total_reg, out_left_reg, out_bin_reg};

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the best-fit two-resource placement block.
`timescale 1ns / 1ps

module tb;

    import bfp_pkg::*;

    localparam int NUM_BINS  = DEF_NUM_BINS;
    localparam int NUM_MODES = DEF_NUM_MODES;

    // The fourth op code has no meaning: the block drops it without a result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles to let pass once the last result is in, so that a dropped
    // transaction still in work has certainly left the block
    localparam int SETTLE_CYCLES = NUM_BINS + 8;

    // Length of the forced receiver hold-off, in cycles
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [MODE_W-1:0] mode;
        logic [AMT_W-1:0]  bw;
        logic [AMT_W-1:0]  pw;
        logic [MASK_W-1:0] mask;
        logic [GAIN_W-1:0] gain;
    } bfp_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [IDX_W-1:0]   bin;
        logic [AMT_W-1:0]   left;
        logic [TOTAL_W-1:0] total;
    } bfp_rsp_t;

    // One row of the directed table; fixed rows carry their result typed in
    typedef struct packed {
        bfp_req_t req;
        bit       fixed;
        bfp_rsp_t want;
    } dir_row_t;

    // Every input starts at a known value from time zero
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;

    // Own copy of the bin table and the running gain, kept in step with the
    // block by applying every accepted transaction to it
    bit                 bin_live [NUM_BINS];
    logic [MODE_W-1:0]  bin_md   [NUM_BINS];
    logic [AMT_W-1:0]   bin_bw   [NUM_BINS];
    logic [AMT_W-1:0]   bin_pw   [NUM_BINS];
    logic [TOTAL_W-1:0] gain_acc;

    bfp_rsp_t pending_results [$];
    dir_row_t dir_rows [$];

    int err_count  = 0;
    int burst_left = 0;
    bit gap_en     = 1'b1;

    // Receiver state: the hold-off is requested by bumping hold_seq
    int         hold_seq  = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         rx_span   = 0;
    int         rx_mode   = 0;
    logic [7:0] rx_tick   = '0;

    bfp_rsp_t seen_rsp;
    bfp_rsp_t head_rsp;

    best_fit_two_resource_placement_top #(
        .NUM_BINS  (NUM_BINS),
        .NUM_MODES (NUM_MODES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Stop a hung run
    initial
    begin
        #150ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t ERROR: %s", $time, msg);
    endfunction

    // Apply one transaction to the table copy and work out its result.
    // Return 0 for the unused op code, which leaves no result.
    function automatic bit placement_step(input bfp_req_t rq, output bfp_rsp_t rs);
        int                 best;
        logic [AMT_W-1:0]   best_lo;
        logic [AMT_W-1:0]   lo;
        logic [AMT_W:0]     sum_bw;
        logic [AMT_W:0]     sum_pw;
        logic [TOTAL_W:0]   gsum;
        bit                 mode_ok;
        rs   = '0;
        best = -1;
        best_lo = '0;
        case (rq.op)
            OP_CONFIG:
            begin
                rs.status = ST_CONFIGURED;
                rs.bin    = rq.idx;
                if (int'(rq.idx) < NUM_BINS)
                begin
                    bin_live[rq.idx] = 1'b1;
                    bin_md[rq.idx]   = rq.mode;
                    bin_bw[rq.idx]   = rq.bw;
                    bin_pw[rq.idx]   = rq.pw;
                    rs.left          = rq.bw;
                end
            end
            OP_PLACE:
            begin
                for (int b = 0; b < NUM_BINS; b++)
                begin
                    mode_ok = (int'(bin_md[b]) < NUM_MODES) && rq.mask[bin_md[b]];
                    if (bin_live[b] && mode_ok && rq.bw <= bin_bw[b] && rq.pw <= bin_pw[b])
                    begin
                        lo = bin_bw[b] - rq.bw;
                        // strict compare keeps the lowest index on a tie
                        if (best < 0 || lo < best_lo)
                        begin
                            best    = b;
                            best_lo = lo;
                        end
                    end
                end
                if (best >= 0)
                begin
                    bin_bw[best] = bin_bw[best] - rq.bw;
                    bin_pw[best] = bin_pw[best] - rq.pw;
                    gsum         = {1'b0, gain_acc} + rq.gain;
                    gain_acc     = gsum[TOTAL_W] ? '1 : gsum[TOTAL_W-1:0];
                    rs.status    = ST_PLACED;
                    rs.bin       = best[IDX_W-1:0];
                    rs.left      = bin_bw[best];
                end
                else
                    rs.status = ST_NO_FIT;
            end
            OP_RELEASE:
            begin
                rs.status = ST_RELEASED;
                rs.bin    = rq.idx;
                if (int'(rq.idx) < NUM_BINS && bin_live[rq.idx])
                begin
                    sum_bw = {1'b0, bin_bw[rq.idx]} + rq.bw;
                    sum_pw = {1'b0, bin_pw[rq.idx]} + rq.pw;
                    bin_bw[rq.idx] = sum_bw[AMT_W] ? '1 : sum_bw[AMT_W-1:0];
                    bin_pw[rq.idx] = sum_pw[AMT_W] ? '1 : sum_pw[AMT_W-1:0];
                    gain_acc = (gain_acc >= rq.gain) ? gain_acc - rq.gain : '0;
                    rs.left  = bin_bw[rq.idx];
                end
            end
            default:
                return 1'b0;
        endcase
        // every result carries the running total after the transaction
        rs.total = gain_acc;
        return 1'b1;
    endfunction

    // Pick a bin, most of the time one that is already configured
    function automatic logic [IDX_W-1:0] pick_bin();
        logic [IDX_W-1:0] b;
        b = IDX_W'($urandom_range(0, NUM_BINS - 1));
        for (int t = 0; t < 8 && !bin_live[b]; t++)
            b = IDX_W'($urandom_range(0, NUM_BINS - 1));
        return b;
    endfunction

    // Build a random transaction, weighted toward placements that can land
    function automatic bfp_req_t rand_req();
        bfp_req_t   rq;
        int         r;
        int         k;
        logic [IDX_W-1:0] b;
        rq.op   = OP_PLACE;
        rq.idx  = IDX_W'($urandom);
        rq.mode = MODE_W'($urandom);
        rq.bw   = AMT_W'($urandom);
        rq.pw   = AMT_W'($urandom);
        rq.mask = MASK_W'($urandom);
        rq.gain = GAIN_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4)
            rq.op = OP_UNUSED;
        else if (r < 20)
        begin
            rq.op = OP_CONFIG;
            if ($urandom_range(0, 3) != 0)
            begin
                rq.bw = AMT_W'($urandom_range(0, 8000));
                rq.pw = AMT_W'($urandom_range(0, 8000));
            end
        end
        else if (r < 45)
        begin
            rq.op = OP_RELEASE;
            if ($urandom_range(0, 99) < 85)
                rq.idx = pick_bin();
            if ($urandom_range(0, 4) != 0)
            begin
                rq.bw = AMT_W'($urandom_range(0, 2000));
                rq.pw = AMT_W'($urandom_range(0, 2000));
            end
            if ($urandom_range(0, 9) < 7)
                rq.gain = GAIN_W'($urandom_range(0, 4000));
        end
        else
        begin
            k = $urandom_range(0, 9);
            b = pick_bin();
            if (k < 7 && bin_live[b])
            begin
                // demand sized to fit a live bin, now and then exactly
                rq.bw   = (k == 0) ? bin_bw[b] : AMT_W'($urandom_range(0, bin_bw[b]));
                rq.pw   = (k == 1) ? bin_pw[b] : AMT_W'($urandom_range(0, bin_pw[b]));
                rq.mask = rq.mask | (16'h0001 << bin_md[b]);
            end
            else if (k < 9)
            begin
                rq.bw   = AMT_W'($urandom_range(0, 3000));
                rq.pw   = AMT_W'($urandom_range(0, 3000));
                rq.mask = 16'h0001 << $urandom_range(0, 15);
            end
        end
        return rq;
    endfunction

    function automatic void add_row(
        input bit fixed, input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
        input logic [MODE_W-1:0] mode, input logic [AMT_W-1:0] bw,
        input logic [AMT_W-1:0] pw, input logic [MASK_W-1:0] mask,
        input logic [GAIN_W-1:0] gain, input logic [STAT_W-1:0] st,
        input logic [IDX_W-1:0] bin, input logic [AMT_W-1:0] left,
        input logic [TOTAL_W-1:0] total);
        dir_row_t row;
        row.req   = '{op, idx, mode, bw, pw, mask, gain};
        row.fixed = fixed;
        row.want  = '{st, bin, left, total};
        dir_rows.push_back(row);
    endfunction

    // Offer one transaction, with a random gap at the start of each burst when gap_en is set,
    // and record its expected result once the block takes it
    task automatic send_txn(input bfp_req_t rq, input bit fixed, input bfp_rsp_t want);
        int       gap;
        bit       has_rsp;
        bfp_rsp_t rs;
        if (gap_en)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 15);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_axis_tvalid <= 1'b0;
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.op;
        s_axis_tdata  <= {rq.gain, rq.mask, rq.pw, rq.bw, rq.mode, rq.idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        has_rsp = placement_step(rq, rs);
        if (has_rsp)
            pending_results.push_back(fixed ? want : rs);
    endtask

    // Pause the sender until every expected result is back, then settle
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int       sent;
        bfp_req_t rq;
        sent = 0;
        while (sent < count)
        begin
            rq = rand_req();
            send_txn(rq, 1'b0, '0);
            // dropped transactions do not count toward the segment
            if (rq.op != OP_UNUSED)
                sent++;
        end
    endtask

    // Receiver: change stall pattern after each random span, and honor a
    // requested long hold-off by counting it down here
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1'b1;
        if (hold_seen != hold_seq)
        begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_span == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_span <= $urandom_range(32, 256);
            end
            else
                rx_span <= rx_span - 1;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
                default: m_axis_tready <= (rx_tick[2:0] != 3'd0);
            endcase
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_rsp.status = m_axis_tuser;
            seen_rsp.bin    = m_axis_tdata[3:0];
            seen_rsp.left   = m_axis_tdata[19:4];
            seen_rsp.total  = m_axis_tdata[51:20];
            if (pending_results.size() == 0)
                note_error($sformatf("unexpected result st=%0d bin=%0d left=%0d total=%0d",
                    seen_rsp.status, seen_rsp.bin, seen_rsp.left, seen_rsp.total));
            else
            begin
                head_rsp = pending_results.pop_front();
                if (seen_rsp.status !== head_rsp.status || seen_rsp.bin !== head_rsp.bin ||
                    seen_rsp.left !== head_rsp.left || seen_rsp.total !== head_rsp.total)
                    note_error($sformatf({"mismatch exp st=%0d bin=%0d left=%0d total=%0d,",
                        " got st=%0d bin=%0d left=%0d total=%0d"},
                        head_rsp.status, head_rsp.bin, head_rsp.left, head_rsp.total,
                        seen_rsp.status, seen_rsp.bin, seen_rsp.left, seen_rsp.total));
            end
        end
    end

    initial
    begin
        bfp_req_t rq;
        int       limit;

        for (int b = 0; b < NUM_BINS; b++)
        begin
            bin_live[b] = 1'b0;
            bin_md[b]   = '0;
            bin_bw[b]   = '0;
            bin_pw[b]   = '0;
        end
        gain_acc = '0;

        // Directed table: empty-table cases first, then extremes, ties,
        // exact fits, each way a placement can fail, and release saturation
        add_row(1, OP_PLACE,   4'd0,  4'd0,  16'h0001, 16'h0001, 16'hFFFF, 16'h0010,
                ST_NO_FIT, 4'd0, 16'd0, 32'd0);
        add_row(1, OP_RELEASE, 4'd9,  4'd0,  16'd100,  16'd100,  16'h0000, 16'd5,
                ST_RELEASED, 4'd9, 16'd0, 32'd0);
        add_row(1, OP_CONFIG,  4'd0,  4'd0,  16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                ST_CONFIGURED, 4'd0, 16'hFFFF, 32'd0);
        add_row(1, OP_CONFIG,  4'd15, 4'd15, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                ST_CONFIGURED, 4'd15, 16'd0, 32'd0);
        add_row(1, OP_CONFIG,  4'd3,  4'd7,  16'd1000, 16'd500,  16'h0000, 16'h0000,
                ST_CONFIGURED, 4'd3, 16'd1000, 32'd0);
        add_row(1, OP_CONFIG,  4'd4,  4'd7,  16'd1000, 16'd500,  16'h0000, 16'h0000,
                ST_CONFIGURED, 4'd4, 16'd1000, 32'd0);
        // tie between bins 3 and 4, the index field is ignored on place
        add_row(0, OP_PLACE,   4'd15, 4'd0,  16'd400,  16'd100,  16'h0080, 16'hFFFF,
                ST_PLACED, 4'd0, 16'd0, 32'd0);
        // bin 3 fits exactly and beats the larger bins
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'd600,  16'd400,  16'hFFFF, 16'hFFFF,
                ST_PLACED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'd1,    16'd1,    16'h0000, 16'h0001,
                ST_NO_FIT, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'd0,    16'd0,    16'h8000, 16'h1234,
                ST_PLACED, 4'd0, 16'd0, 32'd0);
        // bandwidth short, then power short
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'd1,    16'd0,    16'h8000, 16'h0001,
                ST_NO_FIT, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'd10,   16'd600,  16'h0080, 16'h0001,
                ST_NO_FIT, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_UNUSED,  4'hF,  4'hF,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                ST_NO_FIT, 4'd0, 16'd0, 32'd0);
        // resources saturate at the field maximum
        add_row(0, OP_RELEASE, 4'd0,  4'd0,  16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                ST_RELEASED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_RELEASE, 4'd3,  4'd0,  16'd600,  16'd400,  16'h0000, 16'hFFFF,
                ST_RELEASED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_RELEASE, 4'd3,  4'd0,  16'd400,  16'd100,  16'h0000, 16'hFFFF,
                ST_RELEASED, 4'd0, 16'd0, 32'd0);
        // gain total floors at zero
        add_row(0, OP_RELEASE, 4'd15, 4'd0,  16'd0,    16'd0,    16'h0000, 16'hFFFF,
                ST_RELEASED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_CONFIG,  4'd8,  4'd15, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000,
                ST_CONFIGURED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'h5555, 16'hAAAA, 16'hFFFF, 16'hAAAA,
                ST_PLACED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_CONFIG,  4'd10, 4'd10, 16'hAAAA, 16'h5555, 16'h0000, 16'h0000,
                ST_CONFIGURED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'd0,    16'd0,    16'h0400, 16'h5555,
                ST_PLACED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_CONFIG,  4'd2,  4'd5,  16'd300,  16'd300,  16'h0000, 16'h0000,
                ST_CONFIGURED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_PLACE,   4'd0,  4'd0,  16'd300,  16'd300,  16'h0020, 16'h0100,
                ST_PLACED, 4'd0, 16'd0, 32'd0);
        add_row(0, OP_CONFIG,  4'd0,  4'd0,  16'd0,    16'd0,    16'h0000, 16'h0000,
                ST_CONFIGURED, 4'd0, 16'd0, 32'd0);

        // Hold reset from time zero, then release it between edges
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_txn(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
        wait_idle();

        // Random segments: gaps, then a forced receiver hold-off with the
        // sender pressing on, then gaps again, then back-to-back
        run_random(320);
        wait_idle();

        gap_en = 1'b0;
        hold_seq++;
        run_random(320);

        gap_en = 1'b1;
        run_random(320);

        gap_en = 1'b0;
        run_random(320);
        wait_idle();

        // Stack up full-scale gains with zero-size placements into an
        // empty bin, then hand full-scale resources back to that bin
        rq = '{OP_CONFIG, 4'd1, 4'd1, 16'd0, 16'd0, 16'h0000, 16'h0000};
        send_txn(rq, 1'b0, '0);
        rq = '{OP_PLACE, 4'd0, 4'd0, 16'd0, 16'd0, 16'h0002, 16'hFFFF};
        repeat (40)
            send_txn(rq, 1'b0, '0);
        rq = '{OP_RELEASE, 4'd1, 4'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
        send_txn(rq, 1'b0, '0);
        gap_en = 1'b1;
        run_random(40);

        // Drain: wait for the last results, with a bound, then settle
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        limit = 0;
        while (pending_results.size() != 0 && limit < 50000)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                pending_results.size()));

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
src/bfp_pkg.sv
src/bfp_table.sv
src/best_fit_two_resource_placement_top.sv
dv/tb.sv
